// ===== hdl/ffha_pkg.sv =====
// ----------------------------------------------------------------------------
// First-fit heap allocator package
// Shared constants, table entry type and the controller/datapath command set.
// ----------------------------------------------------------------------------
`default_nettype none

package ffha_pkg;

   // Heap geometry.
   localparam int HEAP_BYTES   = 4096;
   localparam int HEADER_BYTES = 24;
   localparam int MAX_BLOCKS   = 64;

   // Derived widths.
   localparam int OFF_W = $clog2(HEAP_BYTES);
   localparam int IDX_W = $clog2(MAX_BLOCKS);
   localparam int CNT_W = IDX_W + 1;

   // Field widths of the request and response.
   localparam int SIZE_W  = 13;
   localparam int ADDR_W  = 13;
   localparam int ST_W    = 3;
   localparam int PADDR_W = 12;

   // Opcodes.
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // Response status codes.
   localparam logic [ST_W-1:0] ST_OK        = 3'd0;
   localparam logic [ST_W-1:0] ST_BAD_SIZE  = 3'd1;
   localparam logic [ST_W-1:0] ST_NO_MEM    = 3'd2;
   localparam logic [ST_W-1:0] ST_OUTSIDE   = 3'd3;
   localparam logic [ST_W-1:0] ST_NOT_START = 3'd4;
   localparam logic [ST_W-1:0] ST_NOT_ALLOC = 3'd5;

   // One block table entry.
   typedef struct packed {
      logic [OFF_W-1:0] offset;
      logic [OFF_W-1:0] size;
      logic             used;
   } entry_type;

   // Datapath operations issued by the controller.
   typedef enum logic [4:0] {
      CMD_NOP,
      CMD_INIT,
      CMD_ACCEPT,
      CMD_READ_IDX,
      CMD_NEXT_IDX,
      CMD_TAKE_CUR,
      CMD_READ_NXT,
      CMD_TAKE_NXT,
      CMD_CLR_NXT,
      CMD_READ_PRV,
      CMD_TAKE_PRV,
      CMD_CLR_PRV,
      CMD_WR_USED,
      CMD_UP_INIT,
      CMD_READ_UP,
      CMD_WRITE_UP,
      CMD_WR_SPLIT,
      CMD_WR_HEAD,
      CMD_MERGE,
      CMD_READ_DN,
      CMD_WRITE_DN,
      CMD_DROP_FIN,
      CMD_RESULT
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type      op;
      logic [ST_W-1:0] code;
   } dp_cmd_type;

   // Status flags reported back to the controller.
   typedef struct packed {
      logic is_free;
      logic bad_size;
      logic outside;
      logic scan_end;
      logic hit;
      logic cur_used;
      logic split;
      logic has_next;
      logic has_prev;
      logic up_done;
      logic dn_done;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== hdl/ffha_if.sv =====
// ----------------------------------------------------------------------------
// First-fit heap allocator channels
// Valid/ready interfaces for the request and response channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface ffha_req_if;
   logic                         valid;
   logic                         ready;
   logic                         opcode;
   logic [ffha_pkg::SIZE_W-1:0]  req_size;
   logic [ffha_pkg::ADDR_W-1:0]  block_addr;

   modport source (output valid, opcode, req_size, block_addr, input ready);
   modport sink   (input valid, opcode, req_size, block_addr, output ready);
endinterface

interface ffha_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [ffha_pkg::ST_W-1:0]    status;
   logic [ffha_pkg::PADDR_W-1:0] payload_addr;

   modport source (output valid, status, payload_addr, input ready);
   modport sink   (input valid, status, payload_addr, output ready);
endinterface

`default_nettype wire

// ===== hdl/first_fit_heap_allocator.sv =====
// An allocate scans the table entries in order; a split also moves each later entry up one
// slot. A free scans the entries the same way, reads both neighbours and on a merge moves
// the later entries down.
// Throughput: one request at a time; the controller accepts a new request only when idle.
// Reset: synchronous, active high; after reset the table is written with one free block.
// ----------------------------------------------------------------------------
// First-fit heap allocator
// Address-ordered block table with first-fit allocation and coalescing free.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_heap_allocator (
   input wire logic  clock,
   input wire logic  reset,
   ffha_req_if.sink  req_chan,
   ffha_rsp_if.source rsp_chan
);

   ffha_pkg::dp_cmd_type    cmd;
   ffha_pkg::dp_status_type status;

   // Sequencer.
   ffha_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Table and arithmetic.
   ffha_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_opcode       (req_chan.opcode),
      .req_size         (req_chan.req_size),
      .req_block_addr   (req_chan.block_addr),
      .status           (status),
      .rsp_status       (rsp_chan.status),
      .rsp_payload_addr (rsp_chan.payload_addr)
   );

endmodule

`default_nettype wire

// ===== hdl/ffha_datapath.sv =====
// ----------------------------------------------------------------------------
// First-fit heap allocator datapath
// Block table memory, scan index, shift pointer and the response registers.
// ----------------------------------------------------------------------------
`default_nettype none

module ffha_datapath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire ffha_pkg::dp_cmd_type          cmd,
   input  wire logic                          req_opcode,
   input  wire logic [ffha_pkg::SIZE_W-1:0]   req_size,
   input  wire logic [ffha_pkg::ADDR_W-1:0]   req_block_addr,
   output ffha_pkg::dp_status_type            status,
   output logic [ffha_pkg::ST_W-1:0]          rsp_status,
   output logic [ffha_pkg::PADDR_W-1:0]       rsp_payload_addr
);

   // Block table.
   ffha_pkg::entry_type mem [ffha_pkg::MAX_BLOCKS];

   ffha_pkg::entry_type rd_ff, cur_ff, nxt_ff, prv_ff;
   logic                             op_ff;
   logic [ffha_pkg::SIZE_W-1:0]      size_ff;
   logic [ffha_pkg::ADDR_W-1:0]      addr_ff;
   logic [ffha_pkg::CNT_W-1:0]       count_ff, count_in;
   logic [ffha_pkg::CNT_W-1:0]       idx_ff;
   logic [ffha_pkg::CNT_W-1:0]       ptr_ff;
   logic [1:0]                       dist_ff;
   logic [ffha_pkg::ST_W-1:0]        st_ff;
   logic [ffha_pkg::PADDR_W-1:0]     paddr_ff;

   logic                             rd_en, wr_en;
   logic [ffha_pkg::IDX_W-1:0]       rd_addr, wr_addr;
   ffha_pkg::entry_type              wr_data;
   logic                             fit, match, prv_free, nxt_free;
   logic [ffha_pkg::OFF_W-1:0]       req_off;
   logic [ffha_pkg::CNT_W:0]         dn_src;

   assign req_off  = ffha_pkg::OFF_W'(size_ff);
   assign prv_free = !prv_ff.used;
   assign nxt_free = !nxt_ff.used;
   assign dn_src   = {1'b0, ptr_ff} + (ffha_pkg::CNT_W + 1)'(dist_ff);
   assign count_in = count_ff;

   // Status flags for the controller.
   always_comb begin
      fit   = !rd_ff.used && (32'(rd_ff.size) >= 32'(size_ff));
      match = (32'(rd_ff.offset) + 32'(ffha_pkg::HEADER_BYTES)) == 32'(addr_ff);
      status.is_free  = (op_ff == ffha_pkg::OP_FREE);
      status.bad_size = (size_ff == '0) ||
                        (32'(size_ff) > 32'(ffha_pkg::HEAP_BYTES - ffha_pkg::HEADER_BYTES));
      status.outside  = 32'(addr_ff) > 32'(ffha_pkg::HEAP_BYTES);
      status.scan_end = (idx_ff == count_ff);
      status.hit      = (op_ff == ffha_pkg::OP_FREE) ? match : fit;
      status.cur_used = cur_ff.used;
      status.split    = ((32'(cur_ff.size) - 32'(size_ff)) > 32'(ffha_pkg::HEADER_BYTES)) &&
                        (count_ff < ffha_pkg::CNT_W'(ffha_pkg::MAX_BLOCKS));
      status.has_next = ({1'b0, idx_ff} + 1'b1) < {1'b0, count_ff};
      status.has_prev = (idx_ff != '0);
      status.up_done  = (ptr_ff == ffha_pkg::CNT_W'(idx_ff + 1'b1));
      status.dn_done  = (dist_ff == 2'd0) || (dn_src >= {1'b0, count_ff});
   end

   // Memory port selection per command.
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = idx_ff[ffha_pkg::IDX_W-1:0];
      wr_en   = 1'b0;
      wr_addr = idx_ff[ffha_pkg::IDX_W-1:0];
      wr_data = cur_ff;
      unique case (cmd.op)
         ffha_pkg::CMD_READ_IDX: begin
            rd_en = 1'b1;
         end
         ffha_pkg::CMD_READ_NXT: begin
            rd_en   = 1'b1;
            rd_addr = ffha_pkg::IDX_W'(idx_ff + 1'b1);
         end
         ffha_pkg::CMD_READ_PRV: begin
            rd_en   = 1'b1;
            rd_addr = ffha_pkg::IDX_W'(idx_ff - 1'b1);
         end
         ffha_pkg::CMD_READ_UP: begin
            rd_en   = 1'b1;
            rd_addr = ffha_pkg::IDX_W'(ptr_ff - 1'b1);
         end
         ffha_pkg::CMD_READ_DN: begin
            rd_en   = 1'b1;
            rd_addr = dn_src[ffha_pkg::IDX_W-1:0];
         end
         ffha_pkg::CMD_INIT: begin
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_data.offset = '0;
            wr_data.size   = ffha_pkg::OFF_W'(ffha_pkg::HEAP_BYTES - ffha_pkg::HEADER_BYTES);
            wr_data.used   = 1'b0;
         end
         ffha_pkg::CMD_WR_USED: begin
            wr_en        = 1'b1;
            wr_data.used = 1'b1;
         end
         ffha_pkg::CMD_WRITE_UP, ffha_pkg::CMD_WRITE_DN: begin
            wr_en   = 1'b1;
            wr_addr = ptr_ff[ffha_pkg::IDX_W-1:0];
            wr_data = rd_ff;
         end
         ffha_pkg::CMD_WR_SPLIT: begin
            wr_en   = 1'b1;
            wr_addr = ffha_pkg::IDX_W'(idx_ff + 1'b1);
            wr_data.offset = ffha_pkg::OFF_W'(32'(cur_ff.offset) +
                             32'(ffha_pkg::HEADER_BYTES) + 32'(req_off));
            wr_data.size   = ffha_pkg::OFF_W'(32'(cur_ff.size) - 32'(req_off) -
                             32'(ffha_pkg::HEADER_BYTES));
            wr_data.used   = 1'b0;
         end
         ffha_pkg::CMD_WR_HEAD: begin
            wr_en        = 1'b1;
            wr_data.size = req_off;
            wr_data.used = 1'b1;
         end
         ffha_pkg::CMD_MERGE: begin
            wr_en        = 1'b1;
            wr_data.used = 1'b0;
            priority if (prv_free && nxt_free) begin
               wr_addr        = ffha_pkg::IDX_W'(idx_ff - 1'b1);
               wr_data.offset = prv_ff.offset;
               wr_data.size   = ffha_pkg::OFF_W'(32'(prv_ff.size) + 32'(cur_ff.size) +
                                32'(nxt_ff.size) + 32'(2 * ffha_pkg::HEADER_BYTES));
            end else if (prv_free) begin
               wr_addr        = ffha_pkg::IDX_W'(idx_ff - 1'b1);
               wr_data.offset = prv_ff.offset;
               wr_data.size   = ffha_pkg::OFF_W'(32'(prv_ff.size) + 32'(cur_ff.size) +
                                32'(ffha_pkg::HEADER_BYTES));
            end else if (nxt_free) begin
               wr_data.size   = ffha_pkg::OFF_W'(32'(cur_ff.size) + 32'(nxt_ff.size) +
                                32'(ffha_pkg::HEADER_BYTES));
            end else begin
               wr_data.size   = cur_ff.size;
            end
         end
         default: begin
         end
      endcase
   end

   // Block table storage with registered read data.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Live entry count.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= ffha_pkg::CNT_W'(1);
      end else begin
         unique case (cmd.op)
            ffha_pkg::CMD_INIT:     count_ff <= ffha_pkg::CNT_W'(1);
            ffha_pkg::CMD_WR_HEAD:  count_ff <= count_in + 1'b1;
            ffha_pkg::CMD_DROP_FIN: count_ff <= count_in - ffha_pkg::CNT_W'(dist_ff);
            default:                count_ff <= count_in;
         endcase
      end
   end

   // Request, index, pointer and result registers.
   // On a merge the pointer marks the first slot to refill after the merged entry.
   always_ff @(posedge clock) begin
      unique case (cmd.op)
         ffha_pkg::CMD_ACCEPT: begin
            op_ff   <= req_opcode;
            size_ff <= req_size;
            addr_ff <= req_block_addr;
            idx_ff  <= '0;
         end
         ffha_pkg::CMD_NEXT_IDX: idx_ff <= idx_ff + 1'b1;
         ffha_pkg::CMD_TAKE_CUR: cur_ff <= rd_ff;
         ffha_pkg::CMD_TAKE_NXT: nxt_ff <= rd_ff;
         ffha_pkg::CMD_CLR_NXT:  nxt_ff.used <= 1'b1;
         ffha_pkg::CMD_TAKE_PRV: prv_ff <= rd_ff;
         ffha_pkg::CMD_CLR_PRV:  prv_ff.used <= 1'b1;
         ffha_pkg::CMD_UP_INIT:  ptr_ff <= count_ff;
         ffha_pkg::CMD_WRITE_UP: ptr_ff <= ptr_ff - 1'b1;
         ffha_pkg::CMD_WRITE_DN: ptr_ff <= ptr_ff + 1'b1;
         ffha_pkg::CMD_MERGE: begin
            priority if (prv_free && nxt_free) begin
               ptr_ff  <= idx_ff;
               dist_ff <= 2'd2;
            end else if (prv_free) begin
               ptr_ff  <= idx_ff;
               dist_ff <= 2'd1;
            end else if (nxt_free) begin
               ptr_ff  <= idx_ff + 1'b1;
               dist_ff <= 2'd1;
            end else begin
               ptr_ff  <= idx_ff;
               dist_ff <= 2'd0;
            end
         end
         ffha_pkg::CMD_WR_USED, ffha_pkg::CMD_WR_HEAD: begin
            st_ff    <= ffha_pkg::ST_OK;
            paddr_ff <= ffha_pkg::PADDR_W'(32'(cur_ff.offset) + 32'(ffha_pkg::HEADER_BYTES));
         end
         ffha_pkg::CMD_DROP_FIN: begin
            st_ff    <= ffha_pkg::ST_OK;
            paddr_ff <= '0;
         end
         ffha_pkg::CMD_RESULT: begin
            st_ff    <= cmd.code;
            paddr_ff <= '0;
         end
         default: begin
         end
      endcase
   end

   assign rsp_status       = st_ff;
   assign rsp_payload_addr = paddr_ff;

endmodule

`default_nettype wire

// ===== hdl/ffha_ctrl.sv =====
// ----------------------------------------------------------------------------
// First-fit heap allocator controller
// Sequences table scans, entry shifts and merges, and runs the handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module ffha_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   input  wire ffha_pkg::dp_status_type   status,
   output ffha_pkg::dp_cmd_type           cmd
);

   typedef enum logic [4:0] {
      S_INIT, S_IDLE, S_CHECK, S_SCAN_RD, S_SCAN_CHK, S_ALLOC_DEC,
      S_UP_RD, S_UP_WR, S_ALLOC_FIN, S_FREE_DEC, S_NXT_RD, S_NXT_TAKE,
      S_PRV_RD, S_PRV_TAKE, S_MERGE, S_DN_RD, S_DN_WR, S_RESP
   } state_type;

   state_type state_ff, state_in;

   // Next state and datapath command.
   always_comb begin
      state_in = state_ff;
      cmd.op   = ffha_pkg::CMD_NOP;
      cmd.code = ffha_pkg::ST_OK;
      unique case (state_ff)
         S_INIT: begin
            cmd.op   = ffha_pkg::CMD_INIT;
            state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = ffha_pkg::CMD_ACCEPT;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            priority if (!status.is_free && status.bad_size) begin
               cmd.op   = ffha_pkg::CMD_RESULT;
               cmd.code = ffha_pkg::ST_BAD_SIZE;
               state_in = S_RESP;
            end else if (status.is_free && status.outside) begin
               cmd.op   = ffha_pkg::CMD_RESULT;
               cmd.code = ffha_pkg::ST_OUTSIDE;
               state_in = S_RESP;
            end else begin
               state_in = S_SCAN_RD;
            end
         end
         S_SCAN_RD: begin
            if (status.scan_end) begin
               cmd.op   = ffha_pkg::CMD_RESULT;
               cmd.code = status.is_free ? ffha_pkg::ST_NOT_START : ffha_pkg::ST_NO_MEM;
               state_in = S_RESP;
            end else begin
               cmd.op   = ffha_pkg::CMD_READ_IDX;
               state_in = S_SCAN_CHK;
            end
         end
         S_SCAN_CHK: begin
            if (status.hit) begin
               cmd.op   = ffha_pkg::CMD_TAKE_CUR;
               state_in = status.is_free ? S_FREE_DEC : S_ALLOC_DEC;
            end else begin
               cmd.op   = ffha_pkg::CMD_NEXT_IDX;
               state_in = S_SCAN_RD;
            end
         end
         S_ALLOC_DEC: begin
            if (status.split) begin
               cmd.op   = ffha_pkg::CMD_UP_INIT;
               state_in = S_UP_RD;
            end else begin
               cmd.op   = ffha_pkg::CMD_WR_USED;
               state_in = S_RESP;
            end
         end
         S_UP_RD: begin
            if (status.up_done) begin
               cmd.op   = ffha_pkg::CMD_WR_SPLIT;
               state_in = S_ALLOC_FIN;
            end else begin
               cmd.op   = ffha_pkg::CMD_READ_UP;
               state_in = S_UP_WR;
            end
         end
         S_UP_WR: begin
            cmd.op   = ffha_pkg::CMD_WRITE_UP;
            state_in = S_UP_RD;
         end
         S_ALLOC_FIN: begin
            cmd.op   = ffha_pkg::CMD_WR_HEAD;
            state_in = S_RESP;
         end
         S_FREE_DEC: begin
            if (!status.cur_used) begin
               cmd.op   = ffha_pkg::CMD_RESULT;
               cmd.code = ffha_pkg::ST_NOT_ALLOC;
               state_in = S_RESP;
            end else begin
               state_in = S_NXT_RD;
            end
         end
         S_NXT_RD: begin
            if (status.has_next) begin
               cmd.op   = ffha_pkg::CMD_READ_NXT;
               state_in = S_NXT_TAKE;
            end else begin
               cmd.op   = ffha_pkg::CMD_CLR_NXT;
               state_in = S_PRV_RD;
            end
         end
         S_NXT_TAKE: begin
            cmd.op   = ffha_pkg::CMD_TAKE_NXT;
            state_in = S_PRV_RD;
         end
         S_PRV_RD: begin
            if (status.has_prev) begin
               cmd.op   = ffha_pkg::CMD_READ_PRV;
               state_in = S_PRV_TAKE;
            end else begin
               cmd.op   = ffha_pkg::CMD_CLR_PRV;
               state_in = S_MERGE;
            end
         end
         S_PRV_TAKE: begin
            cmd.op   = ffha_pkg::CMD_TAKE_PRV;
            state_in = S_MERGE;
         end
         S_MERGE: begin
            cmd.op   = ffha_pkg::CMD_MERGE;
            state_in = S_DN_RD;
         end
         S_DN_RD: begin
            if (status.dn_done) begin
               cmd.op   = ffha_pkg::CMD_DROP_FIN;
               state_in = S_RESP;
            end else begin
               cmd.op   = ffha_pkg::CMD_READ_DN;
               state_in = S_DN_WR;
            end
         end
         S_DN_WR: begin
            cmd.op   = ffha_pkg::CMD_WRITE_DN;
            state_in = S_DN_RD;
         end
         S_RESP: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

endmodule

`default_nettype wire
